@@ rtl/core/contact_distance_histogram_defines.svh @@
// Assertion macros shared by the contact distance histogram checkers.
`ifndef CONTACT_DISTANCE_HISTOGRAM_DEFINES_SVH
`define CONTACT_DISTANCE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CDH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define CDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/cdh_pkg.sv @@
// Types and constants of the contact distance histogram.
`default_nettype none
package cdh_pkg;

   localparam int unsigned CHROM_W = 8;
   localparam int unsigned POS_W   = 31;
   localparam int unsigned SEL_W   = 15;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned WIDTH_W = 31;

   localparam int unsigned NUM_BINS_DEFAULT = 32768;

   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 31'd10000;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [CHROM_W-1:0] chrom_first;
      logic [CHROM_W-1:0] chrom_second;
      logic [POS_W-1:0]   pos_first;
      logic [POS_W-1:0]   pos_second;
      logic [SEL_W-1:0]   bin_select;
   } req_type;

   typedef struct packed {
      logic               counted;
      logic [SEL_W-1:0]   bin_index;
      logic [COUNT_W-1:0] bin_count;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/cdh_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module cdh_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cdh_pkg::POS_W-1:0]   dividend,
   input  logic [cdh_pkg::WIDTH_W-1:0] divisor,
   output logic                        done,
   output logic [cdh_pkg::POS_W-1:0]   quotient
);
   import cdh_pkg::*;

   localparam int unsigned STEPS = POS_W;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic               run_ff,     run_in;
   logic               done_ff,    done_in;
   logic [CNT_W-1:0]   cnt_ff,     cnt_in;
   logic [POS_W-1:0]   shift_ff,   shift_in;
   logic [WIDTH_W-1:0] rem_ff,     rem_in;
   logic [WIDTH_W-1:0] divisor_ff, divisor_in;

   logic [WIDTH_W:0]   trial;
   logic [WIDTH_W+1:0] diff;
   logic               fits;

   // Bring down the next dividend bit and try the subtract.
   assign trial = {rem_ff, shift_ff[POS_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor_ff};
   assign fits  = ~diff[WIDTH_W+1];

   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         run_in     = 1'b1;
         cnt_in     = '0;
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (run_ff) begin
         // Quotient bits shift in where dividend bits shift out.
         shift_in = {shift_ff[POS_W-2:0], fits};
         rem_in   = fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule
`default_nettype wire

@@ rtl/core/cdh_bin_store.sv @@
// Single-port counter memory with registered read data.
`default_nettype none
module cdh_bin_store #(
   parameter int unsigned DEPTH = cdh_pkg::NUM_BINS_DEFAULT
) (
   input  logic                        clock,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  logic                        we,
   input  logic [cdh_pkg::COUNT_W-1:0] wdata,
   output logic [cdh_pkg::COUNT_W-1:0] rd_data
);
   import cdh_pkg::*;

   logic [COUNT_W-1:0] mem_ff [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/contact_distance_histogram.sv @@
// Top level of the contact distance histogram.
// Usage:
//   Input channel: present req_data with start high; the item is taken at a
//   rising edge where start is high and busy is low. cmd selects between
//   counting a contact record and reading one bin.
//   Result channel: exactly one result per item, shown on rsp_data for one
//   cycle while rsp_strobe is high. The receiver cannot stall it.
//   Config: csr_we with csr_wdata writes bin_width; write only while idle.
// Result path (item taken to strobe):
//   different chromosomes, zero bin width or read past the end: next cycle.
//   read of a valid bin: address, then registered memory read.
//   record beyond the last bin: divider start and 31 steps.
//   counted record: the divider plus the read-modify-write of the bin
//   memory.
// Throughput: one item at a time; busy falls with the strobe, so the next
//   item can be taken at the edge that ends its predecessor's result cycle.
// Reset: synchronous; afterward a clearing pass zeroes all NUM_BINS entries of
//   the bin memory one entry per cycle, with busy high. bin_width resets to
//   10000.
`default_nettype none
module contact_distance_histogram #(
   parameter int unsigned NUM_BINS = cdh_pkg::NUM_BINS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  cdh_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output cdh_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [cdh_pkg::WIDTH_W-1:0] csr_wdata
);
   import cdh_pkg::*;

   localparam int unsigned ADDR_W = $clog2(NUM_BINS);
   localparam logic [31:0] NUM_BINS_W = 32'(NUM_BINS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               is_read_ff;
   logic [SEL_W-1:0]   bin_index_ff;
   logic [WIDTH_W-1:0] bin_width_ff;

   logic               accept;
   logic [POS_W:0]     dist_fwd;
   logic [POS_W-1:0]   abs_dist;
   logic               div_start;
   logic               div_done;
   logic [POS_W-1:0]   quotient;
   logic [ADDR_W+SEL_W-1:0] sel_wide;
   logic [ADDR_W-1:0]  sel_addr;
   logic               sel_in_range;
   logic               q_in_range;
   logic               mem_we;
   logic [COUNT_W-1:0] mem_wdata;
   logic [COUNT_W-1:0] rd_data;
   logic [COUNT_W-1:0] bumped;

   assign accept = start && (state_ff == ST_IDLE);

   // Take the absolute distance from whichever subtract does not borrow.
   assign dist_fwd = {1'b0, req_data.pos_second} - {1'b0, req_data.pos_first};
   assign abs_dist = dist_fwd[POS_W] ? (req_data.pos_first - req_data.pos_second)
                                     : dist_fwd[POS_W-1:0];

   assign div_start = accept && (req_data.cmd == CMD_COUNT)
                      && (req_data.chrom_first == req_data.chrom_second)
                      && (bin_width_ff != '0);

   assign sel_wide     = {{ADDR_W{1'b0}}, req_data.bin_select};
   assign sel_addr     = sel_wide[ADDR_W-1:0];
   assign sel_in_range = 32'(req_data.bin_select) < NUM_BINS_W;
   assign q_in_range   = 32'(quotient) < NUM_BINS_W;

   // Saturate at the counter maximum.
   assign bumped    = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_UPDATE) && !is_read_ff);
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : bumped;

   cdh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (abs_dist),
      .divisor  (bin_width_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   cdh_bin_store #(
      .DEPTH (NUM_BINS)
   ) u_bin_store (
      .clock   (clock),
      .addr    (addr_ff),
      .we      (mem_we),
      .wdata   (mem_wdata),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_WIDTH_RESET;
      end else if (csr_we) begin
         bin_width_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  is_read_ff   <= req_data.cmd;
                  bin_index_ff <= req_data.bin_select;
                  if (req_data.cmd == CMD_READ) begin
                     if (sel_in_range) begin
                        addr_ff  <= sel_addr;
                        state_ff <= ST_FETCH;
                     end else begin
                        rsp_ff       <= '{counted: 1'b0, bin_index: req_data.bin_select,
                                          bin_count: '0};
                        rsp_valid_ff <= 1'b1;
                     end
                  end else if (div_start) begin
                     state_ff <= ST_DIVIDE;
                  end else begin
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  if (q_in_range) begin
                     addr_ff      <= quotient[ADDR_W-1:0];
                     bin_index_ff <= quotient[SEL_W-1:0];
                     state_ff     <= ST_FETCH;
                  end else begin
                     // Drop: distance beyond the last bin.
                     rsp_ff       <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (is_read_ff) begin
                  rsp_ff <= '{counted: 1'b0, bin_index: bin_index_ff, bin_count: rd_data};
               end else begin
                  rsp_ff <= '{counted: 1'b1, bin_index: bin_index_ff, bin_count: bumped};
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/cdh_checker.sv @@
// Port-level checks of the contact distance histogram, bound to the top level.
`default_nettype none
`include "contact_distance_histogram_defines.svh"
module cdh_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cdh_pkg::req_type req_data,
   input logic             rsp_strobe,
   input cdh_pkg::rsp_type rsp_data
);
   import cdh_pkg::*;

   logic accept;
   logic counted_rsp;
   logic read_rsp;

   assign accept      = start && !busy;
   assign counted_rsp = rsp_strobe && rsp_data.counted;
   assign read_rsp    = accept && (req_data.cmd == CMD_READ);

   // Every item either occupies the block or answers in the next cycle.
   `CDH_ASSERT_NEXT(a_accept_answers, clock, reset, accept, busy || rsp_strobe)
   // A counted record never reports an empty bin.
   `CDH_ASSERT_IMPL(a_counted_nonzero, clock, reset, counted_rsp, rsp_data.bin_count != '0)
   // A counted record goes through the divider, so the block was busy.
   `CDH_ASSERT_IMPL(a_counted_was_busy, clock, reset, counted_rsp, $past(busy))
   // A read never yields a counted result next cycle.
   `CDH_ASSERT_NEXT(a_read_not_counted, clock, reset, read_rsp, !rsp_data.counted || !rsp_strobe)

endmodule

bind contact_distance_histogram cdh_checker u_cdh_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire

@@ tb/contact_distance_histogram_checker.sv @@
// Checker that predicts and compares every result of the contact distance histogram.
`timescale 1ns / 1ps
module contact_distance_histogram_checker #(
   parameter int unsigned NUM_BINS = cdh_pkg::NUM_BINS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  cdh_pkg::req_type            req_data,
   input  logic                        rsp_strobe,
   input  cdh_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [cdh_pkg::WIDTH_W-1:0] csr_wdata,
   output int                          pending,
   output int                          errors
);
   import cdh_pkg::*;

   logic [COUNT_W-1:0] hist_bins [NUM_BINS];
   logic [WIDTH_W-1:0] width_now;
   rsp_type            owed_results [$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // Apply one item to the histogram and return the result it should produce.
   function automatic rsp_type tally_item(input req_type item);
      rsp_type          res;
      logic [POS_W-1:0] abs_dist;
      logic [63:0]      span;
      logic [POS_W-1:0] bin;
      res = '0;
      if (item.cmd == CMD_READ) begin
         res.bin_index = item.bin_select;
         if (item.bin_select < NUM_BINS) res.bin_count = hist_bins[item.bin_select];
         return res;
      end
      if (item.chrom_first != item.chrom_second || width_now == '0) return res;
      abs_dist = (item.pos_second >= item.pos_first) ? item.pos_second - item.pos_first
                                                     : item.pos_first - item.pos_second;
      span = 64'(width_now) * 64'(NUM_BINS);
      if (64'(abs_dist) >= span) return res;
      bin = abs_dist / width_now;
      if (bin >= NUM_BINS) return res;
      // hold a full counter at its maximum
      if (hist_bins[bin] != COUNT_MAX) hist_bins[bin] = hist_bins[bin] + 1'b1;
      res.counted   = 1'b1;
      res.bin_index = bin[SEL_W-1:0];
      res.bin_count = hist_bins[bin];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         width_now = BIN_WIDTH_RESET;
         for (int i = 0; i < NUM_BINS; i++) hist_bins[i] = '0;
         owed_results.delete();
      end else begin
         // retire the oldest result before taking a new item on the same edge
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               note_mismatch("result with no item outstanding", 64'(rsp_data), 64'd0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.counted !== want.counted)
                  note_mismatch("counted", 64'(rsp_data.counted), 64'(want.counted));
               if (rsp_data.bin_index !== want.bin_index)
                  note_mismatch("bin_index", 64'(rsp_data.bin_index), 64'(want.bin_index));
               if (rsp_data.bin_count !== want.bin_count)
                  note_mismatch("bin_count", 64'(rsp_data.bin_count), 64'(want.bin_count));
            end
         end
         // an item taken on the write edge still sees the old width
         if (start && !busy) owed_results.push_back(tally_item(req_data));
         if (csr_we) width_now = csr_wdata;
      end
      pending <= owed_results.size();
   end

endmodule

@@ tb/contact_distance_histogram_test.sv @@
// Top of the contact distance histogram testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module contact_distance_histogram_test;
   import cdh_pkg::*;

   localparam int unsigned STALL_LIMIT = 150000;
   localparam logic [POS_W-1:0]   POS_MAX   = '1;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

   logic               clock;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic               busy;
   req_type            req_data  = '0;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic [WIDTH_W-1:0] csr_wdata = '0;

   int pending;
   int errors;
   int idle_pct      = 0;
   int items_sent    = 0;
   int widths_set    = 0;
   int stall_cycles  = 0;

   contact_distance_histogram u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   contact_distance_histogram_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved in %0d cycles, %0d results outstanding",
                  stall_cycles, pending);
         $display("[contact_distance_histogram] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_item(input req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   // Drain the block, then load a new bin width.
   task automatic write_width(input logic [WIDTH_W-1:0] w);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy !== 1'b0);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      widths_set++;
   endtask

   function automatic req_type record_item(input logic [CHROM_W-1:0] cf, cs,
                                           input logic [POS_W-1:0] pf, ps);
      req_type item;
      item              = '0;
      item.cmd          = CMD_COUNT;
      item.chrom_first  = cf;
      item.chrom_second = cs;
      item.pos_first    = pf;
      item.pos_second   = ps;
      return item;
   endfunction

   function automatic req_type read_item(input logic [SEL_W-1:0] sel);
      req_type item;
      item            = '0;
      item.cmd        = CMD_READ;
      item.bin_select = sel;
      return item;
   endfunction

   // Favor a few low and high bins so counts build up and reads find them.
   function automatic int unsigned pick_bin();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 7);
      if (r < 80) return $urandom_range(32760, 32767);
      return $urandom_range(0, 32767);
   endfunction

   function automatic req_type random_item(input logic [WIDTH_W-1:0] w);
      req_type         item;
      int unsigned     pick;
      longint unsigned abs_dist;
      int unsigned     d32;
      logic [POS_W-1:0] tmp;
      pick              = $urandom_range(0, 99);
      item.cmd          = CMD_COUNT;
      item.chrom_first  = CHROM_W'($urandom);
      item.chrom_second = CHROM_W'($urandom);
      item.pos_first    = POS_W'($urandom);
      item.pos_second   = POS_W'($urandom);
      item.bin_select   = SEL_W'($urandom);
      if (pick < 20) begin
         item.cmd        = CMD_READ;
         item.bin_select = SEL_W'(pick_bin());
         return item;
      end
      if (pick < 28) begin
         item.cmd = 1'($urandom_range(0, 1));
         return item;
      end
      if (pick < 38) begin
         item.chrom_second = item.chrom_first ^ 8'($urandom_range(1, 255));
         return item;
      end
      item.chrom_second = item.chrom_first;
      if (w == '0) begin
         abs_dist = 64'($urandom_range(0, 1000));
      end else if (pick < 50) begin
         // straddle the top of the histogram range
         abs_dist = 64'(w) * 64'd32768 - 64'd1 + 64'($urandom_range(0, 2));
      end else begin
         abs_dist = 64'(pick_bin()) * 64'(w) + (64'($urandom) % 64'(w));
      end
      if (abs_dist > 64'(POS_MAX)) abs_dist = 64'($urandom_range(0, 32'(POS_MAX)));
      d32             = 32'(abs_dist);
      item.pos_first  = POS_W'($urandom_range(0, 32'(POS_MAX) - d32));
      item.pos_second = item.pos_first + POS_W'(d32);
      if ($urandom_range(0, 1)) begin
         tmp             = item.pos_first;
         item.pos_first  = item.pos_second;
         item.pos_second = tmp;
      end
      return item;
   endfunction

   initial begin : stimulus
      logic [WIDTH_W-1:0] w;
      int unsigned        raw;
      int                 directed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default width 10000: range top is 327679999
      push_item(read_item('0));
      push_item(read_item('1));
      push_item(record_item(8'd0, 8'd0, '0, '0));
      push_item(record_item(8'hFF, 8'hFF, POS_MAX, POS_MAX));
      push_item(record_item(8'd0, 8'hFF, 31'd5, 31'd5));
      push_item(record_item(8'hAA, 8'h55, 31'd1000, 31'd1000));
      push_item(record_item(8'd7, 8'd7, '0, POS_MAX));
      push_item(record_item(8'd9, 8'd9, 31'd327680100, 31'd100));
      push_item(record_item(8'd9, 8'd9, 31'd327680004, 31'd5));
      push_item(record_item(8'd3, 8'd3, 31'd100, 31'd10099));
      push_item(record_item(8'd3, 8'd3, 31'd10100, 31'd100));
      push_item(read_item(15'd1));
      push_item(read_item('1));
      write_width(31'd1);
      push_item(record_item(8'd1, 8'd1, '0, 31'd32767));
      push_item(record_item(8'd1, 8'd1, 31'd32768, '0));
      write_width(WIDTH_MAX);
      push_item(record_item(8'd2, 8'd2, '0, POS_MAX));
      push_item(record_item(8'd2, 8'd2, 31'd1, POS_MAX));
      write_width('0);
      push_item(record_item(8'd4, 8'd4, 31'd10, 31'd10));
      push_item(read_item('0));
      directed = items_sent;

      for (int mode = 0; mode < 3; mode++) begin
         idle_pct = (mode == 0) ? 27 : (mode == 1) ? 46 : 0;
         for (int seg = 0; seg < 5; seg++) begin
            raw = $urandom;
            case (seg)
               0: w = WIDTH_W'($urandom_range(1, 16));
               1: w = WIDTH_W'($urandom_range(5000, 20000));
               2: w = raw[WIDTH_W-1:0];
               3: w = (mode == 0) ? WIDTH_MAX : (mode == 1) ? 31'd1 : '0;
               default: w = WIDTH_W'($urandom_range(17, 4999));
            endcase
            write_width(w);
            repeat (50) push_item(random_item(w));
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy !== 1'b0);
      repeat (40) @(posedge clock);

      $display("%0d items sent: %0d directed, %0d random under %0d bin widths",
               items_sent, directed, items_sent - directed, widths_set);
      $display("widths 0, 1 and max included; sender idle rates 27, 46 and 0 percent");
      if (errors == 0) begin
         $display("[contact_distance_histogram] OK");
      end else begin
         $display("[contact_distance_histogram] ERROR");
      end
      $finish;
   end

endmodule
